// File: sv/assert_macros.svh
// assertion macros shared by the texture sampler rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define BTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also runs during reset
`define BTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/bts_pkg.sv
// shared types and constants of the bilinear texture sampler
// no dependencies
`timescale 1ns / 1ps

package bts_pkg;

   localparam int TEX_DIM_MAX_DEF     = 256;
   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int STORE_AW            = 16;
   localparam int STORE_DEPTH         = 65536;
   localparam int TEXEL_W             = 24;
   localparam int CHAN_W              = 8;
   localparam int OUT_CHAN_W          = 16;
   localparam int CFG_W               = 9;
   localparam int CSR_IDX_W           = 1;

   localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = 1'b1;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

// File: sv/bts_ram.sv
// generic single-write, dual-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: sv/bts_front.sv
// front stages: coordinate clamp and scale, then corner addresses
// depends on bts_pkg
`timescale 1ns / 1ps

module bts_front import bts_pkg::*; #(
   parameter int TEX_DIM_MAX     = TEX_DIM_MAX_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   localparam int F  = COORD_FRAC_BITS,
   localparam int CW = F + 2,
   localparam int DW = $clog2(TEX_DIM_MAX + 1),
   localparam int IW = $clog2(TEX_DIM_MAX)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  stage_en_type                    en,
   input  logic                            in_valid,
   input  logic                            in_mode,
   input  logic [STORE_AW-1:0]             in_addr,
   input  logic [TEXEL_W-1:0]              in_texel,
   input  logic signed [CW-1:0]            in_u,
   input  logic signed [CW-1:0]            in_v,
   input  logic [DW-1:0]                   tex_w,
   input  logic [DW-1:0]                   tex_h,
   output logic                            v1,
   output logic                            v2,
   output logic                            mode2,
   output logic [3:0][STORE_AW-1:0]        addr2,
   output logic [TEXEL_W-1:0]              texel2,
   output logic [F-1:0]                    kx2,
   output logic [F-1:0]                    ky2
);

   localparam int XW = F + 1 + DW;
   localparam int PW = IW + DW;

   function automatic logic [F:0] clamp_coord(input logic [CW-1:0] c);
      logic [F:0] one;
      one = (F + 1)'(1) << F;
      if (c[CW-1]) return '0;
      if (c[F:0] > one) return one;
      return c[F:0];
   endfunction

   logic                v1_ff, v1_in;
   logic                mode1_ff;
   logic [STORE_AW-1:0] addr1_ff;
   logic [TEXEL_W-1:0]  texel1_ff;
   logic [XW-1:0]       x1_ff, x1_in;
   logic [XW-1:0]       y1_ff, y1_in;

   logic                       v2_ff, v2_in;
   logic                       mode2_ff;
   logic [3:0][STORE_AW-1:0]   addr2_ff, addr2_in;
   logic [TEXEL_W-1:0]         texel2_ff;
   logic [F-1:0]               kx2_ff, ky2_ff;

   logic [IW-1:0]       left, up;
   logic [F-1:0]        kx, ky;
   logic [PW-1:0]       row_prod;
   logic [STORE_AW-1:0] row0, row1, col0, col1;

   assign v1_in = en.s1 ? in_valid : v1_ff;
   assign x1_in = XW'(clamp_coord(in_u)) * XW'(tex_w - DW'(1));
   assign y1_in = XW'(clamp_coord(in_v)) * XW'(tex_h - DW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      if (en.s1 && in_valid) begin
         mode1_ff  <= in_mode;
         addr1_ff  <= in_addr;
         texel1_ff <= in_texel;
         x1_ff     <= x1_in;
         y1_ff     <= y1_in;
      end
   end

   assign left     = x1_ff[F +: IW];
   assign up       = y1_ff[F +: IW];
   assign kx       = x1_ff[F-1:0];
   assign ky       = y1_ff[F-1:0];
   assign row_prod = PW'(up) * PW'(tex_w);
   assign row0     = STORE_AW'(row_prod);
   assign row1     = row0 + ((ky != '0) ? STORE_AW'(tex_w) : '0);
   assign col0     = STORE_AW'(left);
   assign col1     = col0 + STORE_AW'(kx != '0);

   always_comb begin
      addr2_in[0] = (mode1_ff == MODE_SAMPLE) ? row0 + col0 : addr1_ff;
      addr2_in[1] = row0 + col1;
      addr2_in[2] = row1 + col0;
      addr2_in[3] = row1 + col1;
   end

   assign v2_in = en.s2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
      if (en.s2 && v1_ff) begin
         mode2_ff  <= mode1_ff;
         addr2_ff  <= addr2_in;
         texel2_ff <= texel1_ff;
         kx2_ff    <= kx;
         ky2_ff    <= ky;
      end
   end

   assign v1     = v1_ff;
   assign v2     = v2_ff;
   assign mode2  = mode2_ff;
   assign addr2  = addr2_ff;
   assign texel2 = texel2_ff;
   assign kx2    = kx2_ff;
   assign ky2    = ky2_ff;

endmodule

// File: sv/bts_blend.sv
// back stages: corner weights, weighted channels, sum and round to q8.8
// depends on bts_pkg
`timescale 1ns / 1ps

module bts_blend import bts_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   localparam int F = COORD_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  stage_en_type                en,
   input  logic                        v2,
   input  logic                        mode2,
   input  logic [F-1:0]                kx2,
   input  logic [F-1:0]                ky2,
   input  logic [3:0][TEXEL_W-1:0]     rd_data,
   output logic                        v3,
   output logic                        v4,
   output logic                        v5,
   output logic [2:0][OUT_CHAN_W-1:0]  chan_out
);

   localparam int WW = 2 * F + 1;
   localparam int PW = CHAN_W + WW;
   localparam int SW = PW + 2;
   localparam int SH = 2 * F - 8;

   logic                  v3_ff, v3_in;
   logic [3:0][WW-1:0]    wt3_ff, wt3_in;
   logic [F:0]            ikx, iky, kxe, kye;

   logic                        v4_ff, v4_in;
   logic [2:0][3:0][PW-1:0]     prod4_ff, prod4_in;

   logic                          v5_ff, v5_in;
   logic [2:0][OUT_CHAN_W-1:0]    chan5_ff, chan5_in;
   logic [2:0][SW-1:0]            sum;

   assign kxe = (F + 1)'(kx2);
   assign kye = (F + 1)'(ky2);
   assign ikx = ((F + 1)'(1) << F) - kxe;
   assign iky = ((F + 1)'(1) << F) - kye;

   always_comb begin
      wt3_in[0] = WW'(ikx) * WW'(iky);
      wt3_in[1] = WW'(kxe) * WW'(iky);
      wt3_in[2] = WW'(ikx) * WW'(kye);
      wt3_in[3] = WW'(kxe) * WW'(kye);
   end

   assign v3_in = en.s3 ? (v2 && mode2 == MODE_SAMPLE) : v3_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int i = 0; i < 4; i++) begin
            prod4_in[c][i] = PW'(rd_data[i][16 - 8 * c +: CHAN_W]) * PW'(wt3_ff[i]);
         end
      end
   end

   assign v4_in = en.s4 ? v3_ff : v4_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = SW'(prod4_ff[c][0]) + SW'(prod4_ff[c][1]) + SW'(prod4_ff[c][2])
                + SW'(prod4_ff[c][3]) + (SW'(1) << (SH - 1));
         chan5_in[c] = sum[c][SH +: OUT_CHAN_W];
      end
   end

   assign v5_in = en.s5 ? v4_ff : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
      if (en.s3 && v2) begin
         wt3_ff <= wt3_in;
      end
      if (en.s4 && v3_ff) begin
         prod4_ff <= prod4_in;
      end
      if (en.s5 && v4_ff) begin
         chan5_ff <= chan5_in;
      end
   end

   assign v3       = v3_ff;
   assign v4       = v4_ff;
   assign v5       = v5_ff;
   assign chan_out = chan5_ff;

endmodule

// File: sv/bilinear_texture_sampler.sv
// Bilinear RGB texture sampler, clamp-to-edge. Takes one item per clock unless rsp_tready stalls
// the pipeline, loads and samples mixed freely; a sample result passes stages s1 to s5 and is
// then offered on the response port, a load is written into the texel memory as it leaves stage
// s2 and is seen by every later sample. The four corners come from two identical 64K x 24
// texel rams that are written together, each giving two reads per cycle; that is what sustains
// one sample a cycle. The memory has no clear after reset: only texels already loaded may be
// sampled.
// depends on bts_pkg, bts_ram, bts_front, bts_blend, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bilinear_texture_sampler import bts_pkg::*; #(
   parameter int TEX_DIM_MAX     = TEX_DIM_MAX_DEF,
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   localparam int CW     = COORD_FRAC_BITS + 2,
   localparam int REQ_DW = ((STORE_AW + 3 * CHAN_W + 2 * CW) + 7) / 8 * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // texel_addr, texel_red, texel_green, texel_blue, coord_u, coord_v, zero fill
   input  logic [REQ_DW-1:0]      req_tdata,
   // mode
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // red_out, green_out, blue_out
   output logic [47:0]            rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   localparam int F   = COORD_FRAC_BITS;
   localparam int DW  = $clog2(TEX_DIM_MAX + 1);
   localparam int XCW = (DW > CFG_W) ? DW : CFG_W;

   function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] d);
      logic [XCW-1:0] e;
      e = XCW'(d);
      if (e == '0) return DW'(1);
      if (e > XCW'(TEX_DIM_MAX)) return DW'(TEX_DIM_MAX);
      return DW'(e);
   endfunction

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [DW-1:0]    tex_w, tex_h;

   stage_en_type                en;
   logic                        v1, v2, v3, v4, v5;
   logic                        mode2;
   logic [3:0][STORE_AW-1:0]    addr2;
   logic [TEXEL_W-1:0]          texel2, in_texel;
   logic [F-1:0]                kx2, ky2;
   logic [3:0][TEXEL_W-1:0]     rd_data;
   logic [2:0][OUT_CHAN_W-1:0]  chan_out;
   logic                        wr_en;

   // configuration
   assign csr_ready = 1'b1;
   assign width_in  = (csr_valid && csr_index == CSR_TEX_WIDTH) ? csr_data : width_ff;
   assign height_in = (csr_valid && csr_index == CSR_TEX_HEIGHT) ? csr_data : height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign tex_w = clamp_dim(width_ff);
   assign tex_h = clamp_dim(height_ff);

   // stage advance, each stage moves when empty or when the next one moves
   always_comb begin
      en.s5 = !v5 || rsp_tready;
      en.s4 = !v4 || en.s5;
      en.s3 = !v3 || en.s4;
      en.s2 = !v2 || en.s3;
      en.s1 = !v1 || en.s2;
   end

   assign req_tready = en.s1;
   assign in_texel   = {req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]};

   bts_front #(
      .TEX_DIM_MAX     (TEX_DIM_MAX),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_mode  (req_tuser),
      .in_addr  (req_tdata[15:0]),
      .in_texel (in_texel),
      .in_u     (req_tdata[40 +: CW]),
      .in_v     (req_tdata[40 + CW +: CW]),
      .tex_w    (tex_w),
      .tex_h    (tex_h),
      .v1       (v1),
      .v2       (v2),
      .mode2    (mode2),
      .addr2    (addr2),
      .texel2   (texel2),
      .kx2      (kx2),
      .ky2      (ky2)
   );

   // both copies take every load so that each holds the full texture
   assign wr_en = v2 && mode2 == MODE_LOAD && en.s3;

   bts_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram_top (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (addr2[0]),
      .wr_data   (texel2),
      .rd_en     (en.s3),
      .rd_addr_a (addr2[0]),
      .rd_addr_b (addr2[1]),
      .rd_data_a (rd_data[0]),
      .rd_data_b (rd_data[1])
   );

   bts_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram_bot (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (addr2[0]),
      .wr_data   (texel2),
      .rd_en     (en.s3),
      .rd_addr_a (addr2[2]),
      .rd_addr_b (addr2[3]),
      .rd_data_a (rd_data[2]),
      .rd_data_b (rd_data[3])
   );

   bts_blend #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_blend (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .v2       (v2),
      .mode2    (mode2),
      .kx2      (kx2),
      .ky2      (ky2),
      .rd_data  (rd_data),
      .v3       (v3),
      .v4       (v4),
      .v5       (v5),
      .chan_out (chan_out)
   );

   assign rsp_tvalid = v5;
   assign rsp_tdata  = {chan_out[2], chan_out[1], chan_out[0]};

   `BTS_ASSERT(a_rsp_range, clock, reset, rsp_tvalid |-> (rsp_tdata[15:0] <= 16'hFF00 && rsp_tdata[31:16] <= 16'hFF00 && rsp_tdata[47:32] <= 16'hFF00), "channel above 255.0")
   `BTS_ASSERT(a_load_no_rsp, clock, reset, (v2 && en.s3 && mode2 == MODE_LOAD) |=> !v3, "load item entered blend stages")
   `BTS_ASSERT(a_corner_hold, clock, reset, (v3 && !en.s4) |=> (v3 && $stable(rd_data)), "corner texels lost during stall")

endmodule
